FILE: rtl/gthe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthe_pkg
// Shared types and constants of the GTP-U header encapsulator: register
// indexes, header field constants and the configuration bundle.
// ----------------------------------------------------------------------------
package gthe_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SOURCE_IP   = 3'd0,
        REG_DEST_IP     = 3'd1,
        REG_TUNNEL_ID   = 3'd2,
        REG_TUNNEL_PORT = 3'd3,
        REG_HOP_LIMIT   = 3'd4
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Outer header geometry
    localparam int          HDR_BYTES = 50;
    localparam int          HDR_IDX_W = 6;
    localparam logic [15:0] LEN_LIMIT = 16'd65499;

    // Header field constants
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] IP_LEN_ADJ    = 16'd36;
    localparam logic [15:0] UDP_LEN_ADJ   = 16'd16;
    localparam logic [7:0]  GTP_FLAGS     = 8'h30;
    localparam logic [7:0]  GTP_TYPE_TPDU = 8'hFF;

    // Register reset values
    localparam logic [31:0] RST_SOURCE_IP   = 32'h0A0A0A01;
    localparam logic [31:0] RST_DEST_IP     = 32'h0A0A0A02;
    localparam logic [31:0] RST_TUNNEL_ID   = 32'h11223344;
    localparam logic [15:0] RST_TUNNEL_PORT = 16'd2152;
    localparam logic [7:0]  RST_HOP_LIMIT   = 8'd64;

    // Width of the unfolded checksum sum (ten 16-bit words fit in 20 bits)
    localparam int SUM_W = 20;

    // Configuration bundle seen by the header generator
    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [31:0] tunnel_id;
        logic [15:0] tunnel_port;
        logic [7:0]  hop_limit;
    } cfg_t;

endpackage

FILE: rtl/gthe_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthe_ifs
// Valid/ready stream interfaces: inner payload bytes in, outer packet bytes
// out.
// ----------------------------------------------------------------------------
interface gthe_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [15:0] inner_len;

    modport source (output valid, output payload_byte, output payload_last,
                    output inner_len, input ready);
    modport sink   (input valid, input payload_byte, input payload_last,
                    input inner_len, output ready);
endinterface

interface gthe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
    logic       length_error;

    modport source (output valid, output out_byte, output run_last,
                    output packet_end, output length_error, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input packet_end, input length_error, output ready);
endinterface

FILE: rtl/gtpu_header_encapsulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpu_header_encapsulator_top
// GTP-U over IPv4/UDP encapsulator: prepends a 50-byte outer header to each
// inner packet and passes the inner bytes through.
// ----------------------------------------------------------------------------
// Inner bytes enter on the payload channel, one byte per beat, and leave on
// the frame channel. Payload bytes flow at one byte per cycle while the
// frame channel is ready; a packet's first byte holds the block while the
// header sequencer emits the 50 header beats and then that byte through the
// single output register, one beat per ready cycle. Unstalled, it takes a new
// inner byte in the same cycle that the previous one's last beat is loaded.
// inner_len is sampled only on the first byte of a packet; payload_last
// alone ends a packet. Lengths above 65499 wrap and raise length_error on
// every beat of that packet. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module gtpu_header_encapsulator_top
    import gthe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    gthe_in_if.sink                payload,
    gthe_out_if.source             frame
);

    cfg_t             cfg;
    logic [SUM_W-1:0] base_sum;
    logic [7:0]       hdr_byte;

    // Item register
    logic                 item_valid_reg;
    logic                 item_start_reg;
    logic                 item_err_reg;
    logic [7:0]           item_byte_reg;
    logic                 item_last_reg;
    logic [15:0]          item_len_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_next;

    // Packet state
    logic at_start_reg;
    logic pkt_err_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_run_last_reg;
    logic       out_packet_end_reg;
    logic       out_error_reg;

    logic load_ok;
    logic item_fire;
    logic item_final;
    logic in_fire;
    logic in_err;

    gthe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .base_sum  (base_sum)
    );

    gthe_hdr_gen u_hdr (
        .cfg       (cfg),
        .base_sum  (base_sum),
        .inner_len (item_len_reg),
        .hdr_idx   (hdr_idx_reg),
        .hdr_byte  (hdr_byte)
    );

    // Handshake and sequencing
    assign load_ok       = !out_valid_reg || frame.ready;
    assign item_fire     = item_valid_reg && load_ok;
    assign item_final    = !item_start_reg || (hdr_idx_reg == HDR_IDX_W'(HDR_BYTES));
    assign payload.ready = !item_valid_reg || (item_fire && item_final);
    assign in_fire       = payload.valid && payload.ready;
    assign in_err        = at_start_reg ? (payload.inner_len > LEN_LIMIT) : pkt_err_reg;

    // Advance the header offset, clear it when the item leaves
    always_comb
    begin
        hdr_idx_next = hdr_idx_reg;
        if (item_fire)
        begin
            if (item_final)
                hdr_idx_next = '0;
            else
                hdr_idx_next = hdr_idx_reg + 1'b1;
        end
    end

    // Item and packet control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            hdr_idx_reg    <= '0;
            at_start_reg   <= 1'b1;
            pkt_err_reg    <= 1'b0;
        end
        else
        begin
            hdr_idx_reg <= hdr_idx_next;
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
                at_start_reg   <= payload.payload_last;
                pkt_err_reg    <= in_err;
            end
            else if (item_fire && item_final)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_start_reg <= at_start_reg;
            item_err_reg   <= in_err;
            item_byte_reg  <= payload.payload_byte;
            item_last_reg  <= payload.payload_last;
            item_len_reg   <= payload.inner_len;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_ok)
            out_valid_reg <= item_valid_reg;
    end

    // Output payload: header byte or the inner byte itself
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            out_byte_reg       <= item_final ? item_byte_reg : hdr_byte;
            out_run_last_reg   <= item_final;
            out_packet_end_reg <= item_final && item_last_reg;
            out_error_reg      <= item_err_reg;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.out_byte     = out_byte_reg;
    assign frame.run_last     = out_run_last_reg;
    assign frame.packet_end   = out_packet_end_reg;
    assign frame.length_error = out_error_reg;

    // Header offset never passes 50 and only runs for a starting item
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= HDR_IDX_W'(HDR_BYTES))
        else $error("header offset out of range");

    a_idx_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_idx_reg != '0) |-> (item_valid_reg && item_start_reg))
        else $error("header offset advanced without a starting item");

    // A packet start first loads a header beat, never the inner byte
    a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item_start_reg && hdr_idx_reg == '0)
        |=> (out_valid_reg && !out_run_last_reg && !out_packet_end_reg))
        else $error("inner byte sent before header");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_packet_end_reg) |-> out_run_last_reg)
        else $error("packet end on a header beat");

endmodule

FILE: rtl/gthe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthe_cfg_regs
// Configuration register file and the registered partial IPv4 checksum sum
// over the header words that depend on configuration only.
// ----------------------------------------------------------------------------
module gthe_cfg_regs
    import gthe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg,
    output logic [SUM_W-1:0]       base_sum
);

    cfg_t             cfg_reg;
    logic [SUM_W-1:0] base_sum_reg;
    logic [SUM_W-1:0] base_sum_next;

    // Write one register per beat; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_ip   <= RST_SOURCE_IP;
            cfg_reg.dest_ip     <= RST_DEST_IP;
            cfg_reg.tunnel_id   <= RST_TUNNEL_ID;
            cfg_reg.tunnel_port <= RST_TUNNEL_PORT;
            cfg_reg.hop_limit   <= RST_HOP_LIMIT;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SOURCE_IP:   cfg_reg.source_ip   <= cfg_wdata;
                REG_DEST_IP:     cfg_reg.dest_ip     <= cfg_wdata;
                REG_TUNNEL_ID:   cfg_reg.tunnel_id   <= cfg_wdata;
                REG_TUNNEL_PORT: cfg_reg.tunnel_port <= cfg_wdata[15:0];
                REG_HOP_LIMIT:   cfg_reg.hop_limit   <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    // Sum the fixed and configured header words (version, TTL/protocol, addresses)
    always_comb
    begin
        base_sum_next = SUM_W'({IP_VER_IHL, 8'h00})
                      + SUM_W'({cfg_reg.hop_limit, IP_PROTO_UDP})
                      + SUM_W'(cfg_reg.source_ip[31:16])
                      + SUM_W'(cfg_reg.source_ip[15:0])
                      + SUM_W'(cfg_reg.dest_ip[31:16])
                      + SUM_W'(cfg_reg.dest_ip[15:0]);
    end

    always_ff @(posedge clk)
    begin
        base_sum_reg <= base_sum_next;
    end

    assign cfg      = cfg_reg;
    assign base_sum = base_sum_reg;

endmodule

FILE: rtl/gthe_hdr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthe_hdr_gen
// Selects one byte of the 50-byte Ethernet/IPv4/UDP/GTP-U outer header by
// its offset, deriving lengths and the folded IPv4 checksum.
// ----------------------------------------------------------------------------
module gthe_hdr_gen
    import gthe_pkg::*;
(
    input  cfg_t                 cfg,
    input  logic [SUM_W-1:0]     base_sum,
    input  logic [15:0]          inner_len,
    input  logic [HDR_IDX_W-1:0] hdr_idx,
    output logic [7:0]           hdr_byte
);

    logic [15:0]      ip_len;
    logic [15:0]      udp_len;
    logic [SUM_W-1:0] full_sum;
    logic [16:0]      fold1;
    logic [16:0]      fold2;
    logic [15:0]      ip_csum;

    // Lengths wrap modulo 2^16
    assign ip_len  = inner_len + IP_LEN_ADJ;
    assign udp_len = inner_len + UDP_LEN_ADJ;

    // Add total length, fold carries twice, complement
    always_comb
    begin
        full_sum = base_sum + SUM_W'(ip_len);
        fold1    = 17'(full_sum[15:0]) + 17'(full_sum[SUM_W-1:16]);
        fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
        ip_csum  = ~fold2[15:0];
    end

    // Byte mux over header offsets; MAC addresses and unset fields are zero
    always_comb
    begin
        case (hdr_idx)
            6'd12:   hdr_byte = ETH_TYPE_IPV4[15:8];
            6'd13:   hdr_byte = ETH_TYPE_IPV4[7:0];
            6'd14:   hdr_byte = IP_VER_IHL;
            6'd16:   hdr_byte = ip_len[15:8];
            6'd17:   hdr_byte = ip_len[7:0];
            6'd22:   hdr_byte = cfg.hop_limit;
            6'd23:   hdr_byte = IP_PROTO_UDP;
            6'd24:   hdr_byte = ip_csum[15:8];
            6'd25:   hdr_byte = ip_csum[7:0];
            6'd26:   hdr_byte = cfg.source_ip[31:24];
            6'd27:   hdr_byte = cfg.source_ip[23:16];
            6'd28:   hdr_byte = cfg.source_ip[15:8];
            6'd29:   hdr_byte = cfg.source_ip[7:0];
            6'd30:   hdr_byte = cfg.dest_ip[31:24];
            6'd31:   hdr_byte = cfg.dest_ip[23:16];
            6'd32:   hdr_byte = cfg.dest_ip[15:8];
            6'd33:   hdr_byte = cfg.dest_ip[7:0];
            6'd34:   hdr_byte = cfg.tunnel_port[15:8];
            6'd35:   hdr_byte = cfg.tunnel_port[7:0];
            6'd36:   hdr_byte = cfg.tunnel_port[15:8];
            6'd37:   hdr_byte = cfg.tunnel_port[7:0];
            6'd38:   hdr_byte = udp_len[15:8];
            6'd39:   hdr_byte = udp_len[7:0];
            6'd42:   hdr_byte = GTP_FLAGS;
            6'd43:   hdr_byte = GTP_TYPE_TPDU;
            6'd44:   hdr_byte = inner_len[15:8];
            6'd45:   hdr_byte = inner_len[7:0];
            6'd46:   hdr_byte = cfg.tunnel_id[31:24];
            6'd47:   hdr_byte = cfg.tunnel_id[23:16];
            6'd48:   hdr_byte = cfg.tunnel_id[15:8];
            6'd49:   hdr_byte = cfg.tunnel_id[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GTP-U header encapsulator. A short directed
// table covers the length limits, zero length, wrapped lengths and packets
// whose byte count disagrees with the stated length. Random packets follow
// under several register settings and idle patterns. Every frame beat is
// compared with the beats predicted from the accepted payload bytes.
// ----------------------------------------------------------------------------
module testbench
    import gthe_pkg::*;
();

    localparam int NUM_DIRECTED    = 20;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 22;
    localparam int MAX_REPORTS     = 40;
    localparam int NUM_REG_SLOTS   = 1 << CFG_INDEX_W;

    // One payload beat to drive, with optional hand-typed expectations
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] len;
        logic        typed;
        logic        t_err;
        logic [15:0] t_ip_len;
    } stim_row_t;

    // One frame beat as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_end;
        logic       length_error;
    } frame_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    gthe_in_if  payload_ch ();
    gthe_out_if frame_ch ();

    // Predictor state: shadow registers and packet tracking
    cfg_t        model_cfg;
    logic        at_pkt_start;
    logic        pkt_err;
    frame_beat_t expected_beats [$];
    stim_row_t   drive_row;
    stim_row_t   directed_rows [NUM_DIRECTED];

    int beat_errors;
    int send_idle_pct;
    int recv_idle_pct;

    gtpu_header_encapsulator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .payload   (payload_ch),
        .frame     (frame_ch)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Build the expected frame beats for one accepted payload byte
    function automatic void predict_encap_beats(input logic [7:0] data, input logic last,
                                                input logic [15:0] len, input logic typed,
                                                input logic t_err,
                                                input logic [15:0] t_ip_len);
        logic [15:0]            ip_len;
        logic [15:0]            udp_len;
        logic [15:0]            ip_len_field;
        logic [15:0]            chk;
        logic [SUM_W-1:0]       csum;
        logic [HDR_BYTES*8-1:0] hdr_bits;
        logic                   err_field;
        frame_beat_t            beat;
        int                     i;
        if (at_pkt_start)
            pkt_err = (len > LEN_LIMIT);
        err_field = typed ? t_err : pkt_err;
        if (at_pkt_start)
        begin
            ip_len  = len + IP_LEN_ADJ;
            udp_len = len + UDP_LEN_ADJ;
            csum = SUM_W'({IP_VER_IHL, 8'h00}) + SUM_W'(ip_len)
                 + SUM_W'({model_cfg.hop_limit, IP_PROTO_UDP})
                 + SUM_W'(model_cfg.source_ip[31:16]) + SUM_W'(model_cfg.source_ip[15:0])
                 + SUM_W'(model_cfg.dest_ip[31:16]) + SUM_W'(model_cfg.dest_ip[15:0]);
            csum = SUM_W'(csum[15:0]) + SUM_W'(csum[SUM_W-1:16]);
            csum = SUM_W'(csum[15:0]) + SUM_W'(csum[SUM_W-1:16]);
            chk  = ~csum[15:0];
            ip_len_field = typed ? t_ip_len : ip_len;
            // Ethernet, IPv4, UDP and GTP-U, first byte in the top bits
            hdr_bits = {96'h0, ETH_TYPE_IPV4,
                        IP_VER_IHL, 8'h00, ip_len_field, 32'h0,
                        model_cfg.hop_limit, IP_PROTO_UDP, chk,
                        model_cfg.source_ip, model_cfg.dest_ip,
                        model_cfg.tunnel_port, model_cfg.tunnel_port, udp_len, 16'h0,
                        GTP_FLAGS, GTP_TYPE_TPDU, len, model_cfg.tunnel_id};
            for (i = 0; i < HDR_BYTES; i++)
            begin
                beat.out_byte     = hdr_bits[(HDR_BYTES-1-i)*8 +: 8];
                beat.run_last     = 1'b0;
                beat.packet_end   = 1'b0;
                beat.length_error = err_field;
                expected_beats.push_back(beat);
            end
        end
        beat.out_byte     = data;
        beat.run_last     = 1'b1;
        beat.packet_end   = last;
        beat.length_error = err_field;
        expected_beats.push_back(beat);
        at_pkt_start = last;
    endfunction

    // Predict on accepted payload beats, check accepted frame beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (payload_ch.valid && payload_ch.ready)
                predict_encap_beats(payload_ch.payload_byte, payload_ch.payload_last,
                                    payload_ch.inner_len, drive_row.typed,
                                    drive_row.t_err, drive_row.t_ip_len);
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    if (beat_errors < MAX_REPORTS)
                        $display("%0t: unexpected beat: expected none, got %h/%b/%b/%b",
                                 $time, frame_ch.out_byte, frame_ch.run_last,
                                 frame_ch.packet_end, frame_ch.length_error);
                    beat_errors++;
                end
                else
                begin
                    if ({frame_ch.out_byte, frame_ch.run_last, frame_ch.packet_end,
                         frame_ch.length_error} !== expected_beats[0])
                    begin
                        if (beat_errors < MAX_REPORTS)
                            $display("%0t: mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                     $time, expected_beats[0].out_byte,
                                     expected_beats[0].run_last, expected_beats[0].packet_end,
                                     expected_beats[0].length_error, frame_ch.out_byte,
                                     frame_ch.run_last, frame_ch.packet_end,
                                     frame_ch.length_error);
                        beat_errors++;
                    end
                    void'(expected_beats.pop_front());
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Drive one payload beat after a random gap, hold until accepted
    task automatic send_byte(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            payload_ch.valid        <= 1'b0;
            payload_ch.payload_byte <= 8'($urandom_range(255));
            payload_ch.payload_last <= 1'($urandom_range(1));
            payload_ch.inner_len    <= 16'($urandom_range(65535));
            @(posedge clk);
        end
        payload_ch.valid        <= 1'b1;
        payload_ch.payload_byte <= row.data;
        payload_ch.payload_last <= row.last;
        payload_ch.inner_len    <= row.len;
        drive_row               <= row;
        @(posedge clk);
        while (!payload_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every predicted beat to come out
    task automatic drain_frames();
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; the caller lowers the write enable afterwards
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_SOURCE_IP:   model_cfg.source_ip   = data;
            REG_DEST_IP:     model_cfg.dest_ip     = data;
            REG_TUNNEL_ID:   model_cfg.tunnel_id   = data;
            REG_TUNNEL_PORT: model_cfg.tunnel_port = data[15:0];
            REG_HOP_LIMIT:   model_cfg.hop_limit   = data[7:0];
            default: ;
        endcase
    endtask

    // Stimulus
    initial
    begin
        int        phase;
        int        r;
        int        i;
        int        b;
        int        sent;
        int        pkt;
        int        nbytes;
        logic [15:0] plen;
        stim_row_t row;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        payload_ch.valid        = 1'b0;
        payload_ch.payload_byte = '0;
        payload_ch.payload_last = 1'b0;
        payload_ch.inner_len    = '0;
        frame_ch.ready          = 1'b0;
        drive_row               = '0;
        beat_errors             = 0;
        send_idle_pct           = 29;
        recv_idle_pct           = 74;
        at_pkt_start            = 1'b1;
        pkt_err                 = 1'b0;
        model_cfg.source_ip     = RST_SOURCE_IP;
        model_cfg.dest_ip       = RST_DEST_IP;
        model_cfg.tunnel_id     = RST_TUNNEL_ID;
        model_cfg.tunnel_port   = RST_TUNNEL_PORT;
        model_cfg.hop_limit     = RST_HOP_LIMIT;

        // byte, last, len, typed, error, IPv4 total length
        directed_rows = '{
            '{8'h00, 1'b1, 16'd1,     1'b1, 1'b0, 16'd37},    // first packet after reset
            '{8'hFF, 1'b1, 16'd0,     1'b1, 1'b0, 16'd36},    // zero length
            '{8'hA5, 1'b0, 16'd65499, 1'b1, 1'b0, 16'd65535}, // largest legal length
            '{8'h5A, 1'b1, 16'hFFFF,  1'b1, 1'b0, 16'd0},     // length ignored mid-packet
            '{8'h01, 1'b1, 16'd65500, 1'b1, 1'b1, 16'd0},     // first oversized length
            '{8'h80, 1'b0, 16'd65535, 1'b1, 1'b1, 16'd35},    // largest length, wrapped
            '{8'h7F, 1'b0, 16'd0,     1'b1, 1'b1, 16'd0},
            '{8'hFF, 1'b1, 16'd1,     1'b1, 1'b1, 16'd0},
            '{8'h55, 1'b1, 16'd1,     1'b1, 1'b0, 16'd37},    // error clears on next packet
            '{8'h12, 1'b0, 16'd5,     1'b0, 1'b0, 16'd0},     // fewer bytes than stated
            '{8'h34, 1'b1, 16'd0,     1'b0, 1'b0, 16'd0},
            '{8'hAA, 1'b0, 16'd2,     1'b0, 1'b0, 16'd0},     // more bytes than stated
            '{8'h55, 1'b0, 16'hAAAA,  1'b0, 1'b0, 16'd0},
            '{8'hC3, 1'b0, 16'h5555,  1'b0, 1'b0, 16'd0},
            '{8'h3C, 1'b1, 16'd0,     1'b0, 1'b0, 16'd0},
            '{8'h0F, 1'b1, 16'hAAAA,  1'b0, 1'b0, 16'd0},
            '{8'hF0, 1'b1, 16'h5555,  1'b0, 1'b0, 16'd0},
            '{8'h00, 1'b0, 16'd3,     1'b0, 1'b0, 16'd0},
            '{8'hFF, 1'b0, 16'd0,     1'b0, 1'b0, 16'd0},
            '{8'h81, 1'b1, 16'hFFFF,  1'b0, 1'b0, 16'd0}
        };

        // Reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table under reset register values
        for (i = 0; i < NUM_DIRECTED; i++)
            send_byte(directed_rows[i]);

        // Random packets under a new register setting per phase
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_frames();
            for (r = 0; r <= int'(REG_HOP_LIMIT); r++)
                write_reg(r[CFG_INDEX_W-1:0], (phase == 0) ? 32'hFFFF_FFFF :
                                              (phase == 1) ? 32'h0 : $urandom);
            // Writes to unmapped indexes must leave every register alone
            if (phase == 1)
                for (r = int'(REG_HOP_LIMIT) + 1; r < NUM_REG_SLOTS; r++)
                    write_reg(r[CFG_INDEX_W-1:0], $urandom);
            cfg_we <= 1'b0;

            case (phase / 2)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            sent = 0;
            pkt  = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                nbytes = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(4, 1);
                if (pkt == 1 && nbytes < 2)
                    nbytes = 2;
                case ($urandom_range(9))
                    6:       plen = 16'($urandom_range(65535));
                    7:       plen = 16'($urandom_range(65535, 65500));
                    8:       plen = 16'd0;
                    9:       plen = 16'($urandom_range(65510, 65490));
                    default: plen = 16'(nbytes);
                endcase
                for (b = 0; b < nbytes; b++)
                begin
                    row.data     = 8'($urandom_range(255));
                    row.last     = (b == nbytes - 1);
                    row.len      = (b == 0) ? plen : 16'($urandom_range(65535));
                    row.typed    = 1'b0;
                    row.t_err    = 1'b0;
                    row.t_ip_len = '0;
                    send_byte(row);
                    sent++;
                    // Hold mid-packet until idle, then change a register
                    if (pkt == 1 && b == 0)
                    begin
                        drain_frames();
                        write_reg(CFG_INDEX_W'($urandom_range(int'(REG_HOP_LIMIT))),
                                  $urandom);
                        cfg_we <= 1'b0;
                    end
                end
                pkt++;
            end
        end

        // Drain and let the pipeline settle
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (expected_beats.size() != 0)
            beat_errors++;
        if (beat_errors == 0)
            $display("PASS gtpu_header_encapsulator_top");
        else
            $display("FAIL gtpu_header_encapsulator_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("FAIL gtpu_header_encapsulator_top");
        $finish;
    end

endmodule
